### hw/rtl/mbps_pkg.sv
package mbps_pkg;

  localparam int ADDR_W        = 48;
  localparam int LENGTH_W      = 7;
  localparam int POS_W         = 6;
  localparam int BYTE_W        = 8;
  localparam int CFG_INDEX_W   = 1;
  localparam int CFG_DATA_W    = 48;
  localparam int QUEUE_DEPTH   = 4;
  localparam int QUEUE_PTR_W   = 2;
  localparam int QUEUE_CNT_W   = 3;

  // Encoding of the action field.
  localparam logic ACTION_LOAD = 1'b0;
  localparam logic ACTION_SCAN = 1'b1;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_PATTERN_LENGTH = 1'b0,
    CFG_BASE_ADDRESS   = 1'b1
  } cfg_index_t;

  typedef enum logic [1:0] {
    OP_NOP  = 2'd0,
    OP_LOAD = 2'd1,
    OP_SCAN = 2'd2
  } op_kind_t;

  typedef struct packed {
    op_kind_t          kind;
    logic [POS_W-1:0]  position;
    logic [BYTE_W-1:0] byte_value;
    logic              must_match;
    logic              last;
  } op_t;

endpackage

### hw/rtl/mbps_in_if.sv
interface mbps_in_if;
  logic                         valid;
  logic                         ready;
  logic                         action;
  logic [mbps_pkg::POS_W-1:0]   position;
  logic [mbps_pkg::BYTE_W-1:0]  byte_value;
  logic                         must_match;
  logic                         last;

  modport source (
    output valid, action, position, byte_value, must_match, last,
    input  ready
  );

  modport sink (
    input  valid, action, position, byte_value, must_match, last,
    output ready
  );
endinterface

### hw/rtl/mbps_out_if.sv
interface mbps_out_if;
  logic                         valid;
  logic                         ready;
  logic                         found;
  logic [mbps_pkg::ADDR_W-1:0]  match_address;

  modport source (
    output valid, found, match_address,
    input  ready
  );

  modport sink (
    input  valid, found, match_address,
    output ready
  );
endinterface

### hw/rtl/mbps_front.sv
module mbps_front #(
  parameter int MAX_PATTERN = 64
) (
  mbps_in_if.sink          in_ch,
  input  logic             queue_full,
  output logic             push,
  output mbps_pkg::op_t    push_op
);

  always_comb begin
    in_ch.ready = !queue_full;
    push        = in_ch.valid && !queue_full;

    push_op.position   = in_ch.position;
    push_op.byte_value = in_ch.byte_value;
    push_op.must_match = in_ch.must_match;
    push_op.last       = in_ch.last;

    // Loads beyond the pattern store become no-ops here so the back end never stores them.
    if (in_ch.action == mbps_pkg::ACTION_SCAN) begin
      push_op.kind = mbps_pkg::OP_SCAN;
    end else if (9'(in_ch.position) < 9'(MAX_PATTERN)) begin
      push_op.kind = mbps_pkg::OP_LOAD;
    end else begin
      push_op.kind = mbps_pkg::OP_NOP;
    end
  end

endmodule

### hw/rtl/mbps_queue.sv
module mbps_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  mbps_pkg::op_t    push_op,
  output logic             full,
  input  logic             pop,
  output logic             head_valid,
  output mbps_pkg::op_t    head_op
);

  mbps_pkg::op_t                        entry_r [mbps_pkg::QUEUE_DEPTH];
  logic [mbps_pkg::QUEUE_PTR_W-1:0]     wr_ptr_r, wr_ptr_nxt;
  logic [mbps_pkg::QUEUE_PTR_W-1:0]     rd_ptr_r, rd_ptr_nxt;
  logic [mbps_pkg::QUEUE_CNT_W-1:0]     count_r, count_nxt;

  always_comb begin
    full       = (count_r == mbps_pkg::QUEUE_CNT_W'(mbps_pkg::QUEUE_DEPTH));
    head_valid = (count_r != '0);
    head_op    = entry_r[rd_ptr_r];

    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_op;
    end
  end

endmodule

### hw/rtl/mbps_back.sv
module mbps_back #(
  parameter int MAX_PATTERN = 64,
  parameter int OFFSET_BITS = 32,
  parameter int IDX_W       = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          head_valid,
  input  mbps_pkg::op_t                 head_op,
  output logic                          head_pop,
  input  logic [IDX_W-1:0]              len_m1,
  input  logic [mbps_pkg::ADDR_W-1:0]   base_address,
  mbps_out_if.source                    out_ch
);

  localparam int FILL_W = $clog2(MAX_PATTERN + 1);
  localparam int FLAT_W = MAX_PATTERN * mbps_pkg::BYTE_W;

  // Window of recent stream bytes, newest at index zero.
  logic [mbps_pkg::BYTE_W-1:0]  window_r  [MAX_PATTERN];
  logic [mbps_pkg::BYTE_W-1:0]  pattern_r [MAX_PATTERN];
  logic [MAX_PATTERN-1:0]       care_r;

  logic [FILL_W-1:0]            fill_r, fill_nxt;
  logic [OFFSET_BITS-1:0]       offset_r, offset_nxt;
  logic                         clear_pending_r;
  logic                         match_seen_r;

  logic                         b_valid_r;
  logic                         b_last_r;

  logic                         res_valid_r;
  logic                         res_found_r;
  logic [mbps_pkg::ADDR_W-1:0]  res_addr_r;

  logic                         adv;
  logic                         take_scan;
  logic                         take_load;
  logic [IDX_W-1:0]             load_idx;
  logic [IDX_W-1:0]             align_shift;
  logic [FLAT_W-1:0]            rev_flat;
  logic [FLAT_W-1:0]            aligned_flat;
  logic [MAX_PATTERN-1:0]       hit;
  logic                         fill_ok;
  logic                         found;
  logic                         not_found;
  logic [OFFSET_BITS-1:0]       start_offset;
  logic [mbps_pkg::ADDR_W-1:0]  match_addr;

  // The whole back end moves together whenever the result register can take a word.
  always_comb begin
    adv       = !res_valid_r || out_ch.ready;
    head_pop  = adv && head_valid;
    take_scan = head_pop && (head_op.kind == mbps_pkg::OP_SCAN);
    take_load = head_pop && (head_op.kind == mbps_pkg::OP_LOAD);
    load_idx  = IDX_W'(head_op.position);

    if (clear_pending_r) begin
      fill_nxt   = FILL_W'(1);
      offset_nxt = OFFSET_BITS'(1);
    end else begin
      fill_nxt   = (fill_r == FILL_W'(MAX_PATTERN)) ? fill_r : fill_r + 1'b1;
      offset_nxt = offset_r + 1'b1;
    end
  end

  // Pattern position j lines up with window byte len_m1 - j. Reversing the window
  // turns that into one right shift of the flattened bytes.
  always_comb begin
    for (int k = 0; k < MAX_PATTERN; k++) begin
      rev_flat[k*mbps_pkg::BYTE_W +: mbps_pkg::BYTE_W] = window_r[MAX_PATTERN-1-k];
    end
    align_shift  = IDX_W'(MAX_PATTERN - 1) - len_m1;
    aligned_flat = rev_flat >> {align_shift, 3'b000};
    for (int j = 0; j < MAX_PATTERN; j++) begin
      hit[j] = (IDX_W'(j) > len_m1) || !care_r[j] ||
               (pattern_r[j] == aligned_flat[j*mbps_pkg::BYTE_W +: mbps_pkg::BYTE_W]);
    end

    fill_ok      = fill_r > FILL_W'(len_m1);
    found        = b_valid_r && !match_seen_r && fill_ok && (&hit);
    not_found    = b_valid_r && b_last_r && !match_seen_r && !found;
    start_offset = offset_r - OFFSET_BITS'(len_m1) - 1'b1;
    match_addr   = base_address + mbps_pkg::ADDR_W'(start_offset);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r          <= '0;
      offset_r        <= '0;
      clear_pending_r <= 1'b0;
      match_seen_r    <= 1'b0;
      care_r          <= '0;
      b_valid_r       <= 1'b0;
      b_last_r        <= 1'b0;
      res_valid_r     <= 1'b0;
    end else begin
      if (take_scan) begin
        fill_r          <= fill_nxt;
        offset_r        <= offset_nxt;
        clear_pending_r <= head_op.last;
      end
      if (take_load) begin
        care_r[load_idx] <= head_op.must_match;
      end
      if (adv) begin
        b_valid_r   <= take_scan;
        b_last_r    <= head_op.last;
        res_valid_r <= found || not_found;
        if (b_valid_r) begin
          if (b_last_r) begin
            match_seen_r <= 1'b0;
          end else if (found) begin
            match_seen_r <= 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take_scan) begin
      window_r[0] <= head_op.byte_value;
      for (int i = 1; i < MAX_PATTERN; i++) begin
        window_r[i] <= window_r[i-1];
      end
    end
    if (take_load) begin
      pattern_r[load_idx] <= head_op.byte_value;
    end
    if (adv) begin
      res_found_r <= found;
      res_addr_r  <= found ? match_addr : '0;
    end
  end

  assign out_ch.valid         = res_valid_r;
  assign out_ch.found         = res_found_r;
  assign out_ch.match_address = res_addr_r;

endmodule

### hw/rtl/masked_byte_pattern_scanner_core.sv
// Throughput: one word per cycle while the result register can take a word; the
// window shift and the parallel masked compare each take one pipeline stage, and
// a four-entry queue decouples input from output.
// Reset (synchronous, rst_n low) empties the queue and pipeline, clears care bits,
// window fill, offset and match flag, and sets pattern length 1, base address 0.
module masked_byte_pattern_scanner_core #(
  parameter int MAX_PATTERN = 64,
  parameter int OFFSET_BITS = 32
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  mbps_in_if.sink                               in_ch,
  mbps_out_if.source                            out_ch,
  input  logic                                  cfg_we,
  input  logic [mbps_pkg::CFG_INDEX_W-1:0]      cfg_index,
  input  logic [mbps_pkg::CFG_DATA_W-1:0]       cfg_wdata
);

  localparam int IDX_W = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;

  logic                           push;
  mbps_pkg::op_t                  push_op;
  logic                           queue_full;
  logic                           head_valid;
  mbps_pkg::op_t                  head_op;
  logic                           head_pop;

  logic [IDX_W-1:0]               len_m1_r, len_m1_nxt;
  logic [mbps_pkg::ADDR_W-1:0]    base_r, base_nxt;
  logic [mbps_pkg::LENGTH_W-1:0]  length_in;

  // The length is stored already clamped to 1..MAX_PATTERN, minus one.
  always_comb begin
    length_in  = cfg_wdata[mbps_pkg::LENGTH_W-1:0];
    len_m1_nxt = len_m1_r;
    base_nxt   = base_r;
    if (cfg_we) begin
      case (cfg_index)
        mbps_pkg::CFG_PATTERN_LENGTH: begin
          if (length_in == '0) begin
            len_m1_nxt = '0;
          end else if (9'(length_in) > 9'(MAX_PATTERN)) begin
            len_m1_nxt = IDX_W'(MAX_PATTERN - 1);
          end else begin
            len_m1_nxt = IDX_W'(length_in - 1'b1);
          end
        end
        mbps_pkg::CFG_BASE_ADDRESS: begin
          base_nxt = cfg_wdata[mbps_pkg::ADDR_W-1:0];
        end
        default: begin
          len_m1_nxt = len_m1_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_m1_r <= '0;
      base_r   <= '0;
    end else begin
      len_m1_r <= len_m1_nxt;
      base_r   <= base_nxt;
    end
  end

  mbps_front #(
    .MAX_PATTERN (MAX_PATTERN)
  ) u_front (
    .in_ch      (in_ch),
    .queue_full (queue_full),
    .push       (push),
    .push_op    (push_op)
  );

  mbps_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_op    (push_op),
    .full       (queue_full),
    .pop        (head_pop),
    .head_valid (head_valid),
    .head_op    (head_op)
  );

  mbps_back #(
    .MAX_PATTERN (MAX_PATTERN),
    .OFFSET_BITS (OFFSET_BITS),
    .IDX_W       (IDX_W)
  ) u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .head_valid   (head_valid),
    .head_op      (head_op),
    .head_pop     (head_pop),
    .len_m1       (len_m1_r),
    .base_address (base_r),
    .out_ch       (out_ch)
  );

endmodule
